// File: rtl/core/i2cmrt_pkg.sv
// Package with the types, codes and constants of the I2C register transfer sequencer.
package i2cmrt_pkg;

  localparam int unsigned LimitWidth   = 8;
  localparam int unsigned CountWidth   = 16;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned OpWidth      = 2;
  localparam int unsigned EventWidth   = 3;
  localparam int unsigned CtrlWidth    = 4;
  localparam int unsigned InDataWidth  = 56;
  localparam int unsigned OutDataWidth = 40;

  localparam logic [LimitWidth-1:0] BusyAbortLimitReset = 8'd20;
  localparam logic [LimitWidth-1:0] RejectMax           = 8'hFF;
  localparam logic [ByteWidth-1:0]  ReadBit             = 8'h01;

  // Bus control bits kept in state, and the repeated-start pulse bit.
  localparam int unsigned CbMaster = 0;
  localparam int unsigned CbTx     = 1;
  localparam int unsigned CbNoAck  = 2;
  localparam int unsigned CbRsta   = 3;

  typedef enum logic [OpWidth-1:0] {
    OP_START_READ  = 2'd0,
    OP_START_WRITE = 2'd1,
    OP_BUS_IRQ     = 2'd2,
    OP_BUS_IRQ_ALT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_REG   = 3'd2,
    PH_RDBIT = 3'd3,
    PH_RX    = 3'd4,
    PH_TX    = 3'd5
  } phase_e;

  typedef enum logic [EventWidth-1:0] {
    EV_NONE        = 3'd0,
    EV_READ_DONE   = 3'd1,
    EV_WRITE_DONE  = 3'd2,
    EV_BUSY_ABORT  = 3'd3,
    EV_ARB_LOST    = 3'd4,
    EV_UNEXPECTED  = 3'd5
  } event_e;

  typedef struct packed {
    logic [OpWidth-1:0]    op;
    logic [ByteWidth-1:0]  device_addr;
    logic [ByteWidth-1:0]  reg_addr;
    logic [CountWidth-1:0] byte_count;
    logic [ByteWidth-1:0]  tx_data;
    logic                  arb_lost;
    logic                  transfer_flag;
    logic [ByteWidth-1:0]  rx_data;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic                  send_valid;
    logic [ByteWidth-1:0]  send_byte;
    logic [CtrlWidth-1:0]  control_bits;
    logic                  rx_valid;
    logic [ByteWidth-1:0]  rx_byte;
    logic [CountWidth-1:0] byte_index;
    event_e                event_code;
  } result_t;

endpackage

// File: rtl/core/i2cmrt_seq.sv
// Phase machine, counters and result logic for one item of the transfer sequencer.
module i2cmrt_seq import i2cmrt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  in_item_t              item_i,
  input  logic                  limit_we_i,
  input  logic [LimitWidth-1:0] limit_i,
  output result_t               res_o
);

  logic [LimitWidth-1:0] limit_q;
  phase_e                phase_q, phase_d;
  logic                  is_read_q, is_read_d;
  logic [ByteWidth-1:0]  dev_q, dev_d;
  logic [ByteWidth-1:0]  reg_q, reg_d;
  logic [CountWidth-1:0] total_q, total_d;
  logic [CountWidth-1:0] done_q, done_d;
  logic [LimitWidth-1:0] rejects_q, rejects_d;
  logic [2:0]            bus_ctrl_q, bus_ctrl_d;
  logic [CountWidth-1:0] done_inc;
  logic [LimitWidth-1:0] rejects_inc;
  logic                  rsta;
  result_t               res;

  assign done_inc    = done_q + 16'd1;
  assign rejects_inc = (rejects_q == RejectMax) ? rejects_q : rejects_q + 8'd1;

  // Next state of the phase machine and its counters.
  always_comb begin
    phase_d    = phase_q;
    is_read_d  = is_read_q;
    dev_d      = dev_q;
    reg_d      = reg_q;
    total_d    = total_q;
    done_d     = done_q;
    rejects_d  = rejects_q;
    bus_ctrl_d = bus_ctrl_q;
    if (!item_i.op[1]) begin
      if (phase_q == PH_IDLE) begin
        dev_d      = item_i.device_addr;
        reg_d      = item_i.reg_addr;
        total_d    = item_i.byte_count;
        is_read_d  = (op_e'(item_i.op) == OP_START_READ);
        rejects_d  = '0;
        done_d     = '0;
        phase_d    = PH_ADDR;
        bus_ctrl_d[CbMaster] = 1'b1;
        bus_ctrl_d[CbTx]     = 1'b1;
      end else begin
        rejects_d = rejects_inc;
        if (rejects_inc >= limit_q) begin
          bus_ctrl_d = '0;
          phase_d    = PH_IDLE;
          rejects_d  = '0;
        end
      end
    end else if (item_i.arb_lost) begin
      bus_ctrl_d = '0;
      phase_d    = PH_IDLE;
    end else if (item_i.transfer_flag && phase_q != PH_IDLE) begin
      unique case (phase_q)
        PH_ADDR:  phase_d = PH_REG;
        PH_REG:   phase_d = is_read_q ? PH_RDBIT : PH_TX;
        PH_RDBIT: begin
          phase_d = PH_RX;
          bus_ctrl_d[CbTx]    = 1'b0;
          bus_ctrl_d[CbNoAck] = 1'b0;
        end
        PH_RX: begin
          done_d = done_inc;
          bus_ctrl_d[CbNoAck] = 1'b1;
          if (done_inc == total_q) begin
            bus_ctrl_d = '0;
            phase_d    = PH_IDLE;
          end
        end
        PH_TX: begin
          done_d = done_inc;
          if (done_inc == total_q) begin
            bus_ctrl_d = '0;
            phase_d    = PH_IDLE;
          end
        end
        default:  phase_d = PH_IDLE;
      endcase
    end
  end

  // Result fields of the item.
  always_comb begin
    res            = '0;
    res.event_code = EV_NONE;
    rsta           = 1'b0;
    if (!item_i.op[1]) begin
      if (phase_q == PH_IDLE) begin
        res.accepted   = 1'b1;
        res.send_valid = 1'b1;
        res.send_byte  = item_i.device_addr;
      end else if (rejects_inc >= limit_q) begin
        res.event_code = EV_BUSY_ABORT;
      end
    end else if (item_i.arb_lost) begin
      res.event_code = EV_ARB_LOST;
    end else if (!item_i.transfer_flag || phase_q == PH_IDLE) begin
      res.event_code = EV_UNEXPECTED;
    end else begin
      unique case (phase_q)
        PH_ADDR: begin
          res.send_valid = 1'b1;
          res.send_byte  = reg_q;
        end
        PH_REG: begin
          res.send_valid = 1'b1;
          if (is_read_q) begin
            rsta          = 1'b1;
            res.send_byte = dev_q | ReadBit;
          end else begin
            res.send_byte  = item_i.tx_data;
            res.byte_index = done_q;
          end
        end
        PH_RDBIT: ;
        PH_RX: begin
          res.rx_valid   = 1'b1;
          res.rx_byte    = item_i.rx_data;
          res.byte_index = done_q;
          if (done_inc == total_q) res.event_code = EV_READ_DONE;
        end
        PH_TX: begin
          if (done_inc == total_q) begin
            res.event_code = EV_WRITE_DONE;
          end else begin
            res.send_valid = 1'b1;
            res.send_byte  = item_i.tx_data;
            res.byte_index = done_inc;
          end
        end
        default: res.event_code = EV_UNEXPECTED;
      endcase
    end
    res.control_bits = {rsta, bus_ctrl_d};
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= BusyAbortLimitReset;
      phase_q    <= PH_IDLE;
      is_read_q  <= 1'b0;
      dev_q      <= '0;
      reg_q      <= '0;
      total_q    <= '0;
      done_q     <= '0;
      rejects_q  <= '0;
      bus_ctrl_q <= '0;
    end else begin
      if (limit_we_i) limit_q <= limit_i;
      if (step_i) begin
        phase_q    <= phase_d;
        is_read_q  <= is_read_d;
        dev_q      <= dev_d;
        reg_q      <= reg_d;
        total_q    <= total_d;
        done_q     <= done_d;
        rejects_q  <= rejects_d;
        bus_ctrl_q <= bus_ctrl_d;
      end
    end
  end

  // The bus is released whenever the sequencer rests in idle.
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> bus_ctrl_q == 3'd0)
    else $error("bus control held while idle");

  a_accept_to_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.accepted |=> phase_q == PH_ADDR && done_q == '0 && rejects_q == '0)
    else $error("accepted start did not enter the address phase");

  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.event_code == EV_BUSY_ABORT |=> phase_q == PH_IDLE && rejects_q == '0)
    else $error("busy abort did not return to idle");

  a_rx_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.rx_valid |-> is_read_q && !res.send_valid)
    else $error("received byte delivered outside a read");

endmodule

// File: rtl/core/i2c_master_register_transfer.sv
// I2C master register transfer sequencer: the top level with its input and result registers.
//
// Input channel s_axis: one beat is a start request (read or write) or a bus interrupt
// event, with the op in tuser and the operands and interrupt status in tdata.
// Output channel m_axis: exactly one result beat for every input beat, in order,
// carrying the bus commands, the received byte, the byte index and an event code.
// The user writes the abort limit for rejected starts through busy_abort_limit_we_i only
// while the block is idle; the block does not check this. It takes effect on the next beat.
// Timing: a beat accepted into the input register is processed by the phase machine, and
// its result is loaded into the output register; a receiver stall can hold it in the input
// register first. Throughput is one beat per cycle while the receiver does not stall, set by
// the single registered pass of the phase machine between the input and output registers.
// When the receiver stalls, the output register holds its beat, the input register
// takes one more beat and then tready falls until the output drains.
// Reset clears the valid flags of both registers, the phase machine (idle, bus released)
// and the counters, and sets the abort limit to 20.
module i2c_master_register_transfer import i2cmrt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // device_addr[7:0], reg_addr[15:8], byte_count[31:16], tx_data[39:32],
  // arb_lost[40], transfer_flag[41], rx_data[49:42], zeros above
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [OpWidth-1:0]      s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // accepted[0], send_valid[1], send_byte[9:2], control_bits[13:10], rx_valid[14],
  // rx_byte[22:15], byte_index[38:23], zero at bit 39
  output logic [OutDataWidth-1:0] m_axis_tdata,
  // event_code[2:0]
  output logic [EventWidth-1:0]   m_axis_tuser,
  input  logic                    busy_abort_limit_we_i,
  input  logic [LimitWidth-1:0]   busy_abort_limit_i
);

  logic     in_valid_q;
  in_item_t in_item_q;
  logic     out_valid_q;
  result_t  out_q;
  result_t  res;
  logic     step;

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  i2cmrt_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_item_q),
    .limit_we_i (busy_abort_limit_we_i),
    .limit_i    (busy_abort_limit_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.op            <= s_axis_tuser;
      in_item_q.device_addr   <= s_axis_tdata[7:0];
      in_item_q.reg_addr      <= s_axis_tdata[15:8];
      in_item_q.byte_count    <= s_axis_tdata[31:16];
      in_item_q.tx_data       <= s_axis_tdata[39:32];
      in_item_q.arb_lost      <= s_axis_tdata[40];
      in_item_q.transfer_flag <= s_axis_tdata[41];
      in_item_q.rx_data       <= s_axis_tdata[49:42];
    end
    if (step) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.byte_index, out_q.rx_byte, out_q.rx_valid,
                          out_q.control_bits, out_q.send_byte, out_q.send_valid,
                          out_q.accepted};
  assign m_axis_tuser  = out_q.event_code;

endmodule

// File: tb/sv/i2c_master_register_transfer_test.sv
// Self-checking testbench for the I2C master register transfer sequencer.
`timescale 1ns / 1ps

module i2c_master_register_transfer_test;
  import i2cmrt_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned MaxReports = 30;

  // Tracks the sequencer state and holds the results owed for accepted beats.
  class transfer_predictor;
    logic [LimitWidth-1:0] abort_limit;
    phase_e                phase;
    logic                  is_read;
    logic [ByteWidth-1:0]  dev_addr;
    logic [ByteWidth-1:0]  reg_addr;
    logic [CountWidth-1:0] total_bytes;
    logic [CountWidth-1:0] done_bytes;
    logic [LimitWidth-1:0] busy_rejects;
    logic [2:0]            bus_ctrl;
    result_t               owed_results[$];
    int unsigned           errors;
    int unsigned           beats_in;
    int unsigned           beats_out;
    int unsigned           event_tally[8];

    function new();
      abort_limit  = BusyAbortLimitReset;
      phase        = PH_IDLE;
      is_read      = 1'b0;
      dev_addr     = '0;
      reg_addr     = '0;
      total_bytes  = '0;
      done_bytes   = '0;
      busy_rejects = '0;
      bus_ctrl     = '0;
      errors       = 0;
      beats_in     = 0;
      beats_out    = 0;
      foreach (event_tally[i]) event_tally[i] = 0;
    endfunction

    function void release_bus();
      bus_ctrl[CbMaster] = 1'b0;
      bus_ctrl[CbTx]     = 1'b0;
      bus_ctrl[CbNoAck]  = 1'b0;
      phase              = PH_IDLE;
    endfunction

    function void report_mismatch(string msg);
      errors++;
      if (errors <= MaxReports) $display("MISMATCH at result %0d: %s", beats_out, msg);
    endfunction

    // Notes an accepted input beat and queues the result it must produce.
    function void take_request(in_item_t it);
      result_t r;
      logic    pulse;
      r = '0;
      r.event_code = EV_NONE;
      pulse = 1'b0;
      beats_in++;
      if (it.op == OP_START_READ || it.op == OP_START_WRITE) begin
        if (phase == PH_IDLE) begin
          dev_addr     = it.device_addr;
          reg_addr     = it.reg_addr;
          total_bytes  = it.byte_count;
          is_read      = (it.op == OP_START_READ);
          busy_rejects = '0;
          done_bytes   = '0;
          phase        = PH_ADDR;
          bus_ctrl[CbMaster] = 1'b1;
          bus_ctrl[CbTx]     = 1'b1;
          r.accepted   = 1'b1;
          r.send_valid = 1'b1;
          r.send_byte  = dev_addr;
        end else begin
          if (busy_rejects != RejectMax) busy_rejects++;
          // A limit of zero is met by the first rejected start.
          if (busy_rejects >= abort_limit) begin
            release_bus();
            busy_rejects = '0;
            r.event_code = EV_BUSY_ABORT;
          end
        end
      end else if (it.arb_lost) begin
        release_bus();
        r.event_code = EV_ARB_LOST;
      end else if (!it.transfer_flag || phase == PH_IDLE) begin
        r.event_code = EV_UNEXPECTED;
      end else begin
        case (phase)
          PH_ADDR: begin
            phase = PH_REG;
            r.send_valid = 1'b1;
            r.send_byte  = reg_addr;
          end
          PH_REG: begin
            r.send_valid = 1'b1;
            if (is_read) begin
              phase       = PH_RDBIT;
              pulse       = 1'b1;
              r.send_byte = dev_addr | ReadBit;
            end else begin
              phase        = PH_TX;
              r.send_byte  = it.tx_data;
              r.byte_index = done_bytes;
            end
          end
          PH_RDBIT: begin
            // The dummy receive switches to receive mode and reports nothing.
            phase = PH_RX;
            bus_ctrl[CbTx]    = 1'b0;
            bus_ctrl[CbNoAck] = 1'b0;
          end
          PH_RX: begin
            r.rx_valid   = 1'b1;
            r.rx_byte    = it.rx_data;
            r.byte_index = done_bytes;
            done_bytes++;
            bus_ctrl[CbNoAck] = 1'b1;
            if (done_bytes == total_bytes) begin
              release_bus();
              r.event_code = EV_READ_DONE;
            end
          end
          PH_TX: begin
            done_bytes++;
            if (done_bytes == total_bytes) begin
              release_bus();
              r.event_code = EV_WRITE_DONE;
            end else begin
              r.send_valid = 1'b1;
              r.send_byte  = it.tx_data;
              r.byte_index = done_bytes;
            end
          end
          default: begin
            phase = PH_IDLE;
            r.event_code = EV_UNEXPECTED;
          end
        endcase
      end
      r.control_bits = {pulse, bus_ctrl};
      event_tally[r.event_code]++;
      owed_results.push_back(r);
    endfunction

    function void check_field(string name, logic [CountWidth-1:0] got,
                              logic [CountWidth-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endfunction

    // Compares one result beat with the oldest owed result.
    function void match_result(logic [OutDataWidth-1:0] data, logic [EventWidth-1:0] user);
      result_t e;
      beats_out++;
      if (owed_results.size() == 0) begin
        report_mismatch("result beat with nothing owed");
        return;
      end
      e = owed_results.pop_front();
      check_field("accepted", CountWidth'(data[0]), CountWidth'(e.accepted));
      check_field("send_valid", CountWidth'(data[1]), CountWidth'(e.send_valid));
      check_field("send_byte", CountWidth'(data[9:2]), CountWidth'(e.send_byte));
      check_field("control_bits", CountWidth'(data[13:10]), CountWidth'(e.control_bits));
      check_field("rx_valid", CountWidth'(data[14]), CountWidth'(e.rx_valid));
      check_field("rx_byte", CountWidth'(data[22:15]), CountWidth'(e.rx_byte));
      check_field("byte_index", data[38:23], e.byte_index);
      check_field("event_code", CountWidth'(user), CountWidth'(e.event_code));
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic [OpWidth-1:0]      s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [EventWidth-1:0]   m_axis_tuser;
  logic                    busy_abort_limit_we_i;
  logic [LimitWidth-1:0]   busy_abort_limit_i;

  transfer_predictor xfer = new();
  bit                quiet = 1'b0;
  int unsigned       cycles = 0;

  i2c_master_register_transfer dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .s_axis_tvalid        (s_axis_tvalid),
    .s_axis_tready        (s_axis_tready),
    .s_axis_tdata         (s_axis_tdata),
    .s_axis_tuser         (s_axis_tuser),
    .m_axis_tvalid        (m_axis_tvalid),
    .m_axis_tready        (m_axis_tready),
    .m_axis_tdata         (m_axis_tdata),
    .m_axis_tuser         (m_axis_tuser),
    .busy_abort_limit_we_i(busy_abort_limit_we_i),
    .busy_abort_limit_i   (busy_abort_limit_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none while quiet.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic in_item_t any_item();
    in_item_t it;
    it.op            = OpWidth'($urandom_range(0, 3));
    it.device_addr   = ByteWidth'($urandom_range(0, 255));
    it.reg_addr      = ByteWidth'($urandom_range(0, 255));
    it.byte_count    = CountWidth'($urandom_range(0, 65535));
    it.tx_data       = ByteWidth'($urandom_range(0, 255));
    it.arb_lost      = 1'($urandom_range(0, 1));
    it.transfer_flag = 1'($urandom_range(0, 1));
    it.rx_data       = ByteWidth'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t make_start(op_e op, logic [CountWidth-1:0] count);
    in_item_t it;
    it = any_item();
    it.op = op;
    it.byte_count = count;
    return it;
  endfunction

  // A clean byte transfer interrupt; the alternate op code shows up now and then.
  function automatic in_item_t irq_item();
    in_item_t it;
    it = any_item();
    it.op = ($urandom_range(0, 9) == 0) ? OP_BUS_IRQ_ALT : OP_BUS_IRQ;
    it.arb_lost = 1'b0;
    it.transfer_flag = 1'b1;
    return it;
  endfunction

  function automatic op_e random_start_op();
    return $urandom_range(0, 1) ? OP_START_WRITE : OP_START_READ;
  endfunction

  // Ready side: random stalls unless quiet.
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) xfer.match_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results still owed", cycles,
             xfer.owed_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_beat(input in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it.rx_data, it.transfer_flag, it.arb_lost, it.tx_data,
                      it.byte_count, it.reg_addr, it.device_addr};
    s_axis_tuser  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready);
    xfer.take_request(it);
  endtask

  // Starts with short counts, since one of them may land while idle and open a transfer.
  task automatic reject_storm(input int unsigned n);
    in_item_t it;
    repeat (n) begin
      it = any_item();
      it.op = random_start_op();
      it.byte_count = CountWidth'($urandom_range(1, 8));
      send_beat(it);
    end
  endtask

  // Sends a start, then interrupts until the sequencer is back to idle.
  task automatic run_transfer(input in_item_t start, input bit clean);
    in_item_t    it;
    int unsigned roll;
    send_beat(start);
    if (!clean && $urandom_range(0, 7) == 0)
      reject_storm($urandom_range(1, (xfer.abort_limit > 29) ? 30 : xfer.abort_limit + 1));
    while (xfer.phase != PH_IDLE) begin
      it = irq_item();
      if (!clean) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) it.arb_lost = 1'b1;
        else if (roll < 8) it.transfer_flag = 1'b0;
        else if (roll < 12) it.op = random_start_op();
        else if (roll < 14) it = any_item();
      end
      send_beat(it);
    end
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned           stop_at;
    int unsigned           roll;
    logic [CountWidth-1:0] count;
    in_item_t              stray;
    stop_at = xfer.beats_in + n;
    while (xfer.beats_in < stop_at) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        stray = any_item();
        stray.byte_count = CountWidth'($urandom_range(1, 8));
        send_beat(stray);
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) count = CountWidth'($urandom_range(1, 4));
      else if (roll < 97) count = CountWidth'($urandom_range(5, 40));
      else count = CountWidth'($urandom_range(41, 200));
      run_transfer(make_start(random_start_op(), count), 1'b0);
    end
    quiet = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (xfer.owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitWidth-1:0] value);
    drain();
    busy_abort_limit_we_i <= 1'b1;
    busy_abort_limit_i    <= value;
    @(posedge clk_i);
    busy_abort_limit_we_i <= 1'b0;
    xfer.abort_limit = value;
  endtask

  initial begin
    in_item_t it;
    in_item_t st;
    rst_ni                <= 1'b0;
    s_axis_tvalid         <= 1'b0;
    s_axis_tdata          <= '0;
    s_axis_tuser          <= '0;
    busy_abort_limit_we_i <= 1'b0;
    busy_abort_limit_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Interrupts while idle: a transfer flag alone is unexpected, a lost
    // arbitration is still reported.
    send_beat(irq_item());
    it = irq_item();
    it.arb_lost = 1'b1;
    send_beat(it);

    st = make_start(OP_START_WRITE, 16'd2);
    st.device_addr = 8'hFF;
    st.reg_addr = 8'h00;
    run_transfer(st, 1'b1);
    st = make_start(OP_START_READ, 16'd1);
    st.device_addr = 8'h00;
    st.reg_addr = 8'hFF;
    run_transfer(st, 1'b1);

    // Longest write, broken by a busy start, a missing flag and lost arbitration
    // that wins over a set transfer flag.
    send_beat(make_start(OP_START_WRITE, 16'hFFFF));
    it = irq_item();
    it.op = OP_BUS_IRQ_ALT;
    send_beat(it);
    send_beat(irq_item());
    reject_storm(1);
    it = irq_item();
    it.transfer_flag = 1'b0;
    send_beat(it);
    it = irq_item();
    it.arb_lost = 1'b1;
    send_beat(it);

    // A zero count read cut short by lost arbitration.
    send_beat(make_start(OP_START_READ, 16'd0));
    repeat (3) send_beat(irq_item());
    it = irq_item();
    it.arb_lost = 1'b1;
    send_beat(it);

    write_limit(8'd1);
    random_traffic(30);
    write_limit(8'd20);
    random_traffic(30);
    write_limit(8'd255);
    send_beat(make_start(random_start_op(), 16'd3));
    reject_storm(255);
    random_traffic(20);
    write_limit(8'd0);
    random_traffic(30);
    write_limit(LimitWidth'($urandom_range(2, 254)));
    random_traffic(40);
    drain();

    $display("Covered %0d beats and %0d results in %0d cycles: %0d reads and %0d writes done,",
             xfer.beats_in, xfer.beats_out, cycles, xfer.event_tally[EV_READ_DONE],
             xfer.event_tally[EV_WRITE_DONE]);
    $display("%0d busy aborts, %0d arbitration losses, %0d unexpected interrupts, limits 0 to 255.",
             xfer.event_tally[EV_BUSY_ABORT], xfer.event_tally[EV_ARB_LOST],
             xfer.event_tally[EV_UNEXPECTED]);
    if (xfer.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
